/* design/plmu_pkg.sv */
`timescale 1ns / 1ps
// Shared types, field widths and helpers for the Potts lattice Metropolis update block.
// No dependencies; every other file of the block imports this package.
package plmu_pkg;

	// Default lattice geometry and spin width
	localparam int SIZE_X_DEF    = 16;
	localparam int SIZE_Y_DEF    = 16;
	localparam int SIZE_Z_DEF    = 16;
	localparam int SPIN_BITS_DEF = 4;

	// Fixed port field widths
	localparam int OP_BITS         = 2;
	localparam int COORD_BITS      = 4;
	localparam int SPIN_FIELD_BITS = 4;
	localparam int DRAW_BITS       = 16;
	localparam int MAG_BITS        = 16;
	localparam int UNLIKE_BITS     = 15;
	localparam int SLAB_BITS       = 4;
	localparam int THRESH_BITS     = 16;
	localparam int CFG_INDEX_BITS  = 3;
	localparam int CFG_DATA_BITS   = 16;
	localparam int COUNT_BITS      = 3;

	// Reset value of the last slab plane register
	localparam logic [SLAB_BITS-1:0] SLAB_LAST_RESET = 4'd15;

	typedef enum logic [OP_BITS-1:0] {
		OP_WRITE   = 2'd0,
		OP_FILL    = 2'd1,
		OP_UPDATE  = 2'd2,
		OP_MEASURE = 2'd3
	} op_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SLAB_FIRST = 3'd0,
		CFG_SLAB_LAST  = 3'd1,
		CFG_THRESH_1   = 3'd2,
		CFG_THRESH_2   = 3'd3,
		CFG_THRESH_3   = 3'd4,
		CFG_THRESH_4   = 3'd5,
		CFG_THRESH_5   = 3'd6,
		CFG_THRESH_6   = 3'd7
	} cfg_reg_t;

	// Which lattice site a read beat fetches, relative to the base site
	typedef enum logic [2:0] {
		SLOT_CENTER = 3'd0,
		SLOT_XP     = 3'd1,
		SLOT_XM     = 3'd2,
		SLOT_YP     = 3'd3,
		SLOT_YM     = 3'd4,
		SLOT_ZP     = 3'd5,
		SLOT_ZM     = 3'd6,
		SLOT_PEEK   = 3'd7
	} slot_t;

	// Controller to datapath
	typedef struct packed {
		logic  load;
		logic  rd_en;
		slot_t slot;
		logic  use_scan;
		logic  wr_site;
		logic  fill_step;
		logic  decide;
		logic  accum;
	} plmu_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic slab_empty;
		logic fill_last;
		logic scan_last;
	} plmu_status_t;

	// Reduce a coordinate field modulo the lattice size by repeated compare and subtract
	function automatic logic [COORD_BITS-1:0] wrap_coord(input logic [COORD_BITS-1:0] v,
		input int size);
		int r;
		int i;
		r = int'(v);
		for (i = 0; i < 8; i++) begin
			if (r >= size) begin
				r = r - size;
			end
		end
		return COORD_BITS'(r);
	endfunction

endpackage

/* design/plmu_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on plmu_pkg for default sizes only.
module plmu_ram
	import plmu_pkg::*;
#(
	parameter int WIDTH = SPIN_BITS_DEF,
	parameter int DEPTH = SIZE_X_DEF * SIZE_Y_DEF * SIZE_Z_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* design/plmu_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the lattice operations: issues read, write and accumulate commands.
// Depends on plmu_pkg for the command, status and operation types.
module plmu_ctrl
	import plmu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [OP_BITS-1:0]  operation,
	input  plmu_status_t        status,
	output plmu_cmd_t           cmd,
	output logic                busy,
	output logic                done
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_WRITE  = 9'b000000010,
		S_FILL   = 9'b000000100,
		S_PEEK   = 9'b000001000,
		S_READ   = 9'b000010000,
		S_DECIDE = 9'b000100000,
		S_ACCUM  = 9'b001000000,
		S_DRAIN  = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	localparam logic [2:0] STEP_LAST = 3'd7;

	state_t     state_q;
	state_t     state_d;
	op_t        op_q;
	logic [2:0] step_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (op_t'(operation))
						OP_WRITE:   state_d = S_WRITE;
						OP_FILL:    state_d = S_FILL;
						OP_UPDATE:  state_d = S_READ;
						OP_MEASURE: state_d = S_PEEK;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_WRITE:  state_d = S_DONE;
			S_FILL: begin
				if (status.fill_last) begin
					state_d = S_DONE;
				end
			end
			S_PEEK:   state_d = status.slab_empty ? S_DRAIN : S_READ;
			S_READ: begin
				if (step_q == STEP_LAST) begin
					state_d = (op_q == OP_UPDATE) ? S_DECIDE : S_ACCUM;
				end
			end
			S_DECIDE: state_d = S_DONE;
			S_ACCUM:  state_d = status.scan_last ? S_DONE : S_READ;
			S_DRAIN:  state_d = S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// State, operation and read step registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_WRITE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				op_q <= op_t'(operation);
			end
			if (state_q == S_READ) begin
				step_q <= step_q + 3'd1;
			end else begin
				step_q <= '0;
			end
		end
	end

	// Decode commands from the current state
	always_comb begin
		cmd           = '0;
		cmd.slot      = SLOT_CENTER;
		cmd.load      = (state_q == S_IDLE) && start;
		cmd.wr_site   = (state_q == S_WRITE);
		cmd.fill_step = (state_q == S_FILL);
		cmd.decide    = (state_q == S_DECIDE);
		cmd.accum     = (state_q == S_ACCUM);
		if (state_q == S_PEEK) begin
			cmd.rd_en = 1'b1;
			cmd.slot  = SLOT_PEEK;
		end else if (state_q == S_READ && step_q != STEP_LAST) begin
			cmd.rd_en    = 1'b1;
			cmd.slot     = slot_t'(step_q);
			cmd.use_scan = (op_q == OP_MEASURE);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

/* design/plmu_datapath.sv */
`timescale 1ns / 1ps
// Lattice memory, configuration registers, neighbor addressing, energy counts and slab sums.
// Depends on plmu_pkg and plmu_ram.
module plmu_datapath
	import plmu_pkg::*;
#(
	parameter int SIZE_X    = SIZE_X_DEF,
	parameter int SIZE_Y    = SIZE_Y_DEF,
	parameter int SIZE_Z    = SIZE_Z_DEF,
	parameter int SPIN_BITS = SPIN_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  plmu_cmd_t                  cmd,
	output plmu_status_t               status,
	input  logic [COORD_BITS-1:0]      coord_x,
	input  logic [COORD_BITS-1:0]      coord_y,
	input  logic [COORD_BITS-1:0]      coord_z,
	input  logic [SPIN_FIELD_BITS-1:0] spin_value,
	input  logic [DRAW_BITS-1:0]       uniform_draw,
	input  logic                       cfg_write_en,
	input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0]   cfg_wdata,
	output logic                       accepted,
	output logic [SPIN_FIELD_BITS-1:0] site_spin,
	output logic [MAG_BITS-1:0]        magnetisation_sum,
	output logic [UNLIKE_BITS-1:0]     unlike_pair_count
);

	localparam int SITES = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int XW    = $clog2(SIZE_X);
	localparam int YW    = $clog2(SIZE_Y);
	localparam int ZW    = $clog2(SIZE_Z);
	localparam int AW    = $clog2(SITES);

	localparam logic [XW-1:0] X_MAX = XW'(SIZE_X - 1);
	localparam logic [YW-1:0] Y_MAX = YW'(SIZE_Y - 1);
	localparam logic [ZW-1:0] Z_MAX = ZW'(SIZE_Z - 1);
	localparam logic [AW-1:0] A_MAX = AW'(SITES - 1);
	localparam logic [AW-1:0] X_STRIDE = AW'(SIZE_Y * SIZE_Z);
	localparam logic [AW-1:0] Y_STRIDE = AW'(SIZE_Z);

	// Configuration registers
	logic [SLAB_BITS-1:0]   slab_first_q;
	logic [SLAB_BITS-1:0]   slab_last_q;
	logic [THRESH_BITS-1:0] thresh_q [6];

	// Captured item
	logic [XW-1:0]        cx_q;
	logic [YW-1:0]        cy_q;
	logic [ZW-1:0]        cz_q;
	logic [SPIN_BITS-1:0] spin_in_q;
	logic [DRAW_BITS-1:0] draw_q;

	// Scan and fill counters
	logic [XW-1:0] sx_q;
	logic [YW-1:0] sy_q;
	logic [ZW-1:0] sz_q;
	logic [AW-1:0] fill_addr_q;

	// Read beat tracking, registered in step with the memory's registered read data
	logic  rd_valid_s1;
	slot_t rd_slot_s1;

	// Working values and results
	logic [SPIN_BITS-1:0]       center_q;
	logic [COUNT_BITS-1:0]      cnew_q;
	logic [COUNT_BITS-1:0]      cold_q;
	logic                       accepted_q;
	logic [SPIN_FIELD_BITS-1:0] site_spin_q;
	logic [MAG_BITS-1:0]        mag_q;
	logic [UNLIKE_BITS-1:0]     unlike_q;

	// Memory ports
	logic                 ram_wr_en;
	logic [AW-1:0]        ram_wr_addr;
	logic [AW-1:0]        ram_rd_addr;
	logic [SPIN_BITS-1:0] ram_rd_data;
	logic [AW-1:0]        center_addr;

	// Combinational helpers
	logic [XW-1:0]          first_sat;
	logic [XW-1:0]          last_sat;
	logic [XW-1:0]          bx;
	logic [YW-1:0]          by;
	logic [ZW-1:0]          bz;
	logic [XW-1:0]          nx;
	logic [YW-1:0]          ny;
	logic [ZW-1:0]          nz;
	logic [COUNT_BITS-1:0]  rise;
	logic [THRESH_BITS-1:0] thresh_sel;
	logic                   take;
	logic                   change;
	logic [MAG_BITS:0]      mag_sum;
	logic [UNLIKE_BITS:0]   unlike_sum;

	// Clamp the slab bounds to the last x plane
	always_comb begin
		first_sat = (int'(slab_first_q) > SIZE_X - 1) ? X_MAX : XW'(slab_first_q);
		last_sat  = (int'(slab_last_q) > SIZE_X - 1) ? X_MAX : XW'(slab_last_q);
	end

	// Pick the base site and step to the neighbor for this read beat
	always_comb begin
		bx = cmd.use_scan ? sx_q : cx_q;
		by = cmd.use_scan ? sy_q : cy_q;
		bz = cmd.use_scan ? sz_q : cz_q;
		nx = bx;
		ny = by;
		nz = bz;
		unique case (cmd.slot)
			SLOT_XP: nx = (bx == X_MAX) ? '0 : bx + XW'(1);
			SLOT_XM: nx = (bx == '0) ? X_MAX : bx - XW'(1);
			SLOT_YP: ny = (by == Y_MAX) ? '0 : by + YW'(1);
			SLOT_YM: ny = (by == '0) ? Y_MAX : by - YW'(1);
			SLOT_ZP: nz = (bz == Z_MAX) ? '0 : bz + ZW'(1);
			SLOT_ZM: nz = (bz == '0) ? Z_MAX : bz - ZW'(1);
			SLOT_CENTER, SLOT_PEEK: begin
			end
			default: begin
			end
		endcase
		ram_rd_addr = AW'(nx) * X_STRIDE + AW'(ny) * Y_STRIDE + AW'(nz);
		center_addr = AW'(cx_q) * X_STRIDE + AW'(cy_q) * Y_STRIDE + AW'(cz_q);
	end

	// Metropolis acceptance from the registered unlike counts
	always_comb begin
		rise = cnew_q - cold_q;
		unique case (rise)
			3'd1:    thresh_sel = thresh_q[0];
			3'd2:    thresh_sel = thresh_q[1];
			3'd3:    thresh_sel = thresh_q[2];
			3'd4:    thresh_sel = thresh_q[3];
			3'd5:    thresh_sel = thresh_q[4];
			3'd6:    thresh_sel = thresh_q[5];
			default: thresh_sel = '0;
		endcase
		take   = (cnew_q <= cold_q) || (draw_q < thresh_sel);
		change = take && (spin_in_q != center_q);
	end

	// Saturating slab sums
	always_comb begin
		mag_sum    = {1'b0, mag_q} + (MAG_BITS + 1)'(center_q);
		unlike_sum = {1'b0, unlike_q} + (UNLIKE_BITS + 1)'(cold_q);
	end

	// Memory write port
	always_comb begin
		ram_wr_en   = cmd.wr_site || cmd.fill_step || (cmd.decide && change);
		ram_wr_addr = cmd.fill_step ? fill_addr_q : center_addr;
	end

	plmu_ram #(
		.WIDTH(SPIN_BITS),
		.DEPTH(SITES)
	) u_lattice (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(spin_in_q),
		.rd_en  (cmd.rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slab_first_q <= '0;
			slab_last_q  <= SLAB_LAST_RESET;
			for (int i = 0; i < 6; i++) begin
				thresh_q[i] <= '0;
			end
		end else if (cfg_write_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_SLAB_FIRST: slab_first_q <= cfg_wdata[SLAB_BITS-1:0];
				CFG_SLAB_LAST:  slab_last_q  <= cfg_wdata[SLAB_BITS-1:0];
				CFG_THRESH_1:   thresh_q[0]  <= cfg_wdata[THRESH_BITS-1:0];
				CFG_THRESH_2:   thresh_q[1]  <= cfg_wdata[THRESH_BITS-1:0];
				CFG_THRESH_3:   thresh_q[2]  <= cfg_wdata[THRESH_BITS-1:0];
				CFG_THRESH_4:   thresh_q[3]  <= cfg_wdata[THRESH_BITS-1:0];
				CFG_THRESH_5:   thresh_q[4]  <= cfg_wdata[THRESH_BITS-1:0];
				CFG_THRESH_6:   thresh_q[5]  <= cfg_wdata[THRESH_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Track which slot the memory returns next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			rd_slot_s1  <= SLOT_CENTER;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			rd_slot_s1  <= cmd.slot;
		end
	end

	// Item capture, counters, read beat capture and results
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q        <= XW'(wrap_coord(coord_x, SIZE_X));
			cy_q        <= YW'(wrap_coord(coord_y, SIZE_Y));
			cz_q        <= ZW'(wrap_coord(coord_z, SIZE_Z));
			spin_in_q   <= SPIN_BITS'(spin_value);
			draw_q      <= uniform_draw;
			site_spin_q <= SPIN_FIELD_BITS'(SPIN_BITS'(spin_value));
			accepted_q  <= 1'b0;
			mag_q       <= '0;
			unlike_q    <= '0;
			sx_q        <= first_sat;
			sy_q        <= '0;
			sz_q        <= '0;
			fill_addr_q <= '0;
		end
		if (cmd.fill_step) begin
			fill_addr_q <= fill_addr_q + AW'(1);
		end
		if (rd_valid_s1) begin
			unique case (rd_slot_s1)
				SLOT_CENTER: begin
					center_q <= ram_rd_data;
					cnew_q   <= '0;
					cold_q   <= '0;
				end
				SLOT_PEEK: site_spin_q <= SPIN_FIELD_BITS'(ram_rd_data);
				default: begin
					cnew_q <= cnew_q + COUNT_BITS'(ram_rd_data != spin_in_q);
					cold_q <= cold_q + COUNT_BITS'(ram_rd_data != center_q);
				end
			endcase
		end
		if (cmd.decide) begin
			accepted_q  <= change;
			site_spin_q <= SPIN_FIELD_BITS'(change ? spin_in_q : center_q);
		end
		if (cmd.accum) begin
			mag_q    <= mag_sum[MAG_BITS] ? '1 : mag_sum[MAG_BITS-1:0];
			unlike_q <= unlike_sum[UNLIKE_BITS] ? '1 : unlike_sum[UNLIKE_BITS-1:0];
			// Advance z fastest, then y, then x
			if (sz_q == Z_MAX) begin
				sz_q <= '0;
				if (sy_q == Y_MAX) begin
					sy_q <= '0;
					sx_q <= sx_q + XW'(1);
				end else begin
					sy_q <= sy_q + YW'(1);
				end
			end else begin
				sz_q <= sz_q + ZW'(1);
			end
		end
	end

	// Status to the controller
	always_comb begin
		status.slab_empty = (first_sat > last_sat);
		status.fill_last  = (fill_addr_q == A_MAX);
		status.scan_last  = (sx_q == last_sat) && (sy_q == Y_MAX) && (sz_q == Z_MAX);
	end

	assign accepted          = accepted_q;
	assign site_spin         = site_spin_q;
	assign magnetisation_sum = mag_q;
	assign unlike_pair_count = unlike_q;

endmodule

/* design/potts_lattice_metropolis_update_top.sv */
`timescale 1ns / 1ps
// Potts lattice Metropolis update: top level joining the sequencer and the datapath.
// Depends on plmu_pkg, plmu_ctrl, plmu_datapath (and plmu_ram below it).
//
// An operation is taken when start is high and busy is low; its result shows for one
// cycle with done high, and must be taken in that cycle. All lattice traffic goes
// through the single read port and single write port of the lattice memory, which sets
// the steps: a site write is one write; a Metropolis update reads the site and its six
// neighbors (seven reads), then decides and writes, then raises done; a fill writes every
// site in turn; a slab measurement peeks the site, then for each slab site reads it and
// its six neighbors and accumulates (an empty slab skips the scan). The lattice holds no
// defined contents after reset; write or fill it before updating or measuring.
module potts_lattice_metropolis_update_top
	import plmu_pkg::*;
#(
	parameter int SIZE_X    = SIZE_X_DEF,
	parameter int SIZE_Y    = SIZE_Y_DEF,
	parameter int SIZE_Z    = SIZE_Z_DEF,
	parameter int SPIN_BITS = SPIN_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [OP_BITS-1:0]         operation,
	input  logic [COORD_BITS-1:0]      coord_x,
	input  logic [COORD_BITS-1:0]      coord_y,
	input  logic [COORD_BITS-1:0]      coord_z,
	input  logic [SPIN_FIELD_BITS-1:0] spin_value,
	input  logic [DRAW_BITS-1:0]       uniform_draw,
	input  logic                       cfg_write_en,
	input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0]   cfg_wdata,
	output logic                       done,
	output logic                       accepted,
	output logic [SPIN_FIELD_BITS-1:0] site_spin,
	output logic [MAG_BITS-1:0]        magnetisation_sum,
	output logic [UNLIKE_BITS-1:0]     unlike_pair_count
);

	plmu_cmd_t    cmd;
	plmu_status_t status;

	plmu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operation(operation),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	plmu_datapath #(
		.SIZE_X   (SIZE_X),
		.SIZE_Y   (SIZE_Y),
		.SIZE_Z   (SIZE_Z),
		.SPIN_BITS(SPIN_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.coord_x          (coord_x),
		.coord_y          (coord_y),
		.coord_z          (coord_z),
		.spin_value       (spin_value),
		.uniform_draw     (uniform_draw),
		.cfg_write_en     (cfg_write_en),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.accepted         (accepted),
		.site_spin        (site_spin),
		.magnetisation_sum(magnetisation_sum),
		.unlike_pair_count(unlike_pair_count)
	);

endmodule

/* design/plmu_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the Potts lattice Metropolis update block, bound to the top level.
// Depends on plmu_pkg for port widths.
module plmu_checker
	import plmu_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic                       accepted,
	input logic [MAG_BITS-1:0]        magnetisation_sum,
	input logic [UNLIKE_BITS-1:0]     unlike_pair_count
);

	// A taken start keeps the block busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("busy not raised after a start beat");

	// A result beat only comes while an operation is in flight
	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result beat while idle");

	// The block frees up right after its result beat
	assert property (@(posedge clk) disable iff (!arst_n) done |=> (!busy && !done))
		else $error("block still busy after result beat");

	// An accepted update carries no measurement sums
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted) |-> (magnetisation_sum == '0 && unlike_pair_count == '0))
		else $error("accepted update with nonzero slab sums");

endmodule

bind potts_lattice_metropolis_update_top plmu_checker u_plmu_checker (.*);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for potts_lattice_metropolis_update_top: a directed table, then random
// phases of fill, box writes and mixed updates, checked against typed rows or an in-bench lattice mirror.
// Depends on plmu_pkg and the design files of the block.
module tb_top;
	import plmu_pkg::*;

	localparam int SX = SIZE_X_DEF;
	localparam int SY = SIZE_Y_DEF;
	localparam int SZ = SIZE_Z_DEF;
	localparam int SITES = SX * SY * SZ;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 150;
	localparam int BOX_WRITES = 20;
	localparam int TAIL_CYCLES = 30;
	// the slowest legal runs come from fills, slab scans and gaps
	localparam int LIMIT_CYCLES = 2_000_000;

	typedef struct {
		op_t                        op;
		logic [COORD_BITS-1:0]      x, y, z;
		logic                       acc;
		logic [SPIN_FIELD_BITS-1:0] site;
		logic [MAG_BITS-1:0]        mag;
		logic [UNLIKE_BITS-1:0]     unl;
	} site_result_t;

	typedef struct {
		bit                         is_reg;
		cfg_reg_t                   idx;
		logic [CFG_DATA_BITS-1:0]   data;
		op_t                        op;
		logic [COORD_BITS-1:0]      x, y, z;
		logic [SPIN_FIELD_BITS-1:0] spin;
		logic [DRAW_BITS-1:0]       draw;
		bit                         typed;
		site_result_t               want;
	} stim_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [OP_BITS-1:0]         operation;
	logic [COORD_BITS-1:0]      coord_x;
	logic [COORD_BITS-1:0]      coord_y;
	logic [COORD_BITS-1:0]      coord_z;
	logic [SPIN_FIELD_BITS-1:0] spin_value;
	logic [DRAW_BITS-1:0]       uniform_draw;
	logic                       cfg_write_en;
	logic [CFG_INDEX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0]   cfg_wdata;
	logic                       done;
	logic                       accepted;
	logic [SPIN_FIELD_BITS-1:0] site_spin;
	logic [MAG_BITS-1:0]        magnetisation_sum;
	logic [UNLIKE_BITS-1:0]     unlike_pair_count;

	// Mirror of the lattice and of the registers
	logic [SPIN_FIELD_BITS-1:0] spin_mirror [SITES];
	logic [SLAB_BITS-1:0]       slab_lo;
	logic [SLAB_BITS-1:0]       slab_hi;
	logic [THRESH_BITS-1:0]     rise_limit [1:6];

	site_result_t pending_results[$];
	stim_row_t    stim_rows[$];

	int  errors;
	int  cycle_count;
	int  n_items, n_updates, n_taken, n_writes, n_fills, n_measures, n_reg_writes;
	bit  calm;
	int  spin_span;
	logic [COORD_BITS-1:0] box_x, box_y, box_z;

	potts_lattice_metropolis_update_top i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Count cycles and stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_top: timeout after %0d cycles", cycle_count);
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic flag(input string msg);
		$display("tb_top: mismatch: %s", msg);
		errors++;
	endtask

	function automatic int site_at(input int x, input int y, input int z);
		return ((x % SX) * SY + (y % SY)) * SZ + (z % SZ);
	endfunction

	// Neighbors with periodic wrap whose spin differs from s
	function automatic int unlike_neighbours(input int x, input int y, input int z,
		input logic [SPIN_FIELD_BITS-1:0] s);
		int n;
		n = 0;
		n += int'(spin_mirror[site_at(x + 1, y, z)] != s);
		n += int'(spin_mirror[site_at(x + SX - 1, y, z)] != s);
		n += int'(spin_mirror[site_at(x, y + 1, z)] != s);
		n += int'(spin_mirror[site_at(x, y + SY - 1, z)] != s);
		n += int'(spin_mirror[site_at(x, y, z + 1)] != s);
		n += int'(spin_mirror[site_at(x, y, z + SZ - 1)] != s);
		return n;
	endfunction

	// Apply one operation to the mirror and work out its result beat
	task automatic apply_operation(input stim_row_t row, output site_result_t r);
		int at, cur_n, new_n, lo, hi, i, j, k;
		int unsigned mag_acc, unl_acc;
		logic [SPIN_FIELD_BITS-1:0] old;
		bit take;
		at = site_at(row.x, row.y, row.z);
		r.op = row.op;
		r.x = row.x;
		r.y = row.y;
		r.z = row.z;
		r.acc = 1'b0;
		r.mag = '0;
		r.unl = '0;
		n_items++;
		case (row.op)
			OP_WRITE: begin
				spin_mirror[at] = row.spin;
				n_writes++;
			end
			OP_FILL: begin
				foreach (spin_mirror[n]) spin_mirror[n] = row.spin;
				n_fills++;
			end
			OP_UPDATE: begin
				n_updates++;
				old = spin_mirror[at];
				new_n = unlike_neighbours(row.x, row.y, row.z, row.spin);
				cur_n = unlike_neighbours(row.x, row.y, row.z, old);
				if (new_n <= cur_n) begin
					take = 1'b1;
				end else begin
					take = row.draw < rise_limit[new_n - cur_n];
				end
				if (take && row.spin != old) begin
					spin_mirror[at] = row.spin;
					r.acc = 1'b1;
					n_taken++;
				end
			end
			default: begin
				n_measures++;
				lo = (slab_lo > SX - 1) ? SX - 1 : slab_lo;
				hi = (slab_hi > SX - 1) ? SX - 1 : slab_hi;
				mag_acc = 0;
				unl_acc = 0;
				for (i = lo; i <= hi; i++) begin
					for (j = 0; j < SY; j++) begin
						for (k = 0; k < SZ; k++) begin
							mag_acc += spin_mirror[site_at(i, j, k)];
							unl_acc += unlike_neighbours(i, j, k, spin_mirror[site_at(i, j, k)]);
						end
					end
				end
				r.mag = (mag_acc > 32'hFFFF) ? '1 : MAG_BITS'(mag_acc);
				r.unl = (unl_acc > 32'h7FFF) ? '1 : UNLIKE_BITS'(unl_acc);
			end
		endcase
		r.site = spin_mirror[at];
	endtask

	// Present one beat, hold it until taken, then queue its expected result
	task automatic send_row(input stim_row_t row);
		int gap;
		site_result_t r;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 7) gap = $urandom_range(1, 12);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		operation <= row.op;
		coord_x <= row.x;
		coord_y <= row.y;
		coord_z <= row.z;
		spin_value <= row.spin;
		uniform_draw <= row.draw;
		@(posedge clk);
		while (busy) @(posedge clk);
		apply_operation(row, r);
		if (row.typed) begin
			row.want.op = row.op;
			row.want.x = row.x;
			row.want.y = row.y;
			row.want.z = row.z;
			pending_results.push_back(row.want);
		end else begin
			pending_results.push_back(r);
		end
	endtask

	// Drop start and wait until every result is back and the block is idle
	task automatic wait_idle;
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0 || busy) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		n_reg_writes++;
		case (idx)
			CFG_SLAB_FIRST: slab_lo = data[SLAB_BITS-1:0];
			CFG_SLAB_LAST:  slab_hi = data[SLAB_BITS-1:0];
			default:        rise_limit[int'(idx) - int'(CFG_THRESH_1) + 1] = data;
		endcase
	endtask

	task automatic add_reg(input cfg_reg_t idx, input int data);
		stim_row_t row;
		row.is_reg = 1'b1;
		row.typed = 1'b0;
		row.idx = idx;
		row.data = CFG_DATA_BITS'(data);
		stim_rows.push_back(row);
	endtask

	// typed = 0 leaves the expectation to the mirror
	task automatic add_row(input op_t op, input int x, input int y, input int z, input int s,
		input int d, input bit typed, input int acc, input int site, input int mag,
		input int unl);
		stim_row_t row;
		row.is_reg = 1'b0;
		row.op = op;
		row.x = COORD_BITS'(x);
		row.y = COORD_BITS'(y);
		row.z = COORD_BITS'(z);
		row.spin = SPIN_FIELD_BITS'(s);
		row.draw = DRAW_BITS'(d);
		row.typed = typed;
		row.want.acc = acc[0];
		row.want.site = SPIN_FIELD_BITS'(site);
		row.want.mag = MAG_BITS'(mag);
		row.want.unl = UNLIKE_BITS'(unl);
		stim_rows.push_back(row);
	endtask

	// Mostly near the phase box so updates see written neighbors, sometimes anywhere
	function automatic logic [COORD_BITS-1:0] near(input logic [COORD_BITS-1:0] base);
		if ($urandom_range(0, 99) < 70) return base + COORD_BITS'($urandom_range(0, 2));
		return COORD_BITS'($urandom_range(0, 15));
	endfunction

	function automatic stim_row_t random_row();
		stim_row_t row;
		int w;
		row.is_reg = 1'b0;
		row.typed = 1'b0;
		w = $urandom_range(0, 99);
		if (w < 82) row.op = OP_UPDATE;
		else if (w < 94) row.op = OP_WRITE;
		else if (w < 99) row.op = OP_MEASURE;
		else row.op = OP_FILL;
		row.x = near(box_x);
		row.y = near(box_y);
		row.z = near(box_z);
		if ($urandom_range(0, 99) < 85) row.spin = SPIN_FIELD_BITS'($urandom_range(0, spin_span - 1));
		else row.spin = SPIN_FIELD_BITS'($urandom_range(0, 15));
		// aim some draws right at a threshold edge
		w = $urandom_range(0, 99);
		if (w < 10) row.draw = DRAW_BITS'(rise_limit[$urandom_range(1, 6)] + $urandom_range(0, 2) - 1);
		else if (w < 13) row.draw = '0;
		else if (w < 15) row.draw = '1;
		else row.draw = DRAW_BITS'($urandom_range(0, 65535));
		return row;
	endfunction

	// Check each result beat against the oldest expectation
	always @(posedge clk) begin
		site_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				flag($sformatf("result beat with nothing outstanding (acc %0d site %0d)",
					accepted, site_spin));
			end else begin
				e = pending_results.pop_front();
				if (accepted !== e.acc || site_spin !== e.site || magnetisation_sum !== e.mag ||
					unlike_pair_count !== e.unl) begin
					flag($sformatf("%s (%0d,%0d,%0d): got acc %0d site %0d mag %0d unl %0d, want %0d %0d %0d %0d",
						e.op.name(), e.x, e.y, e.z, accepted, site_spin, magnetisation_sum,
						unlike_pair_count, e.acc, e.site, e.mag, e.unl));
				end
			end
		end
	end

	initial begin
		int p, k, sel, lo_v, hi_v;
		bit in_reg;
		stim_row_t row;
		logic [CFG_DATA_BITS-1:0] data;

		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_WRITE;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		spin_value = '0;
		uniform_draw = '0;
		cfg_write_en = 1'b0;
		cfg_index = CFG_SLAB_FIRST;
		cfg_wdata = '0;
		errors = 0;
		cycle_count = 0;
		calm = 1'b0;
		spin_span = 16;
		box_x = '0;
		box_y = '0;
		box_z = '0;
		slab_lo = '0;
		slab_hi = SLAB_LAST_RESET;
		foreach (rise_limit[i]) rise_limit[i] = '0;
		foreach (spin_mirror[i]) spin_mirror[i] = '0;

		// Directed rows: reset settings first (full slab, all thresholds zero)
		add_row(OP_FILL,     5,  6,  7, 15,     0, 1, 0, 15,     0, 0);
		add_row(OP_MEASURE,  1,  2,  3,  0,     0, 1, 0, 15, 61440, 0);
		// zero threshold rejects the maximum rise
		add_row(OP_UPDATE,   0,  0,  0,  0,     0, 1, 0, 15,     0, 0);
		// proposal equal to the current spin
		add_row(OP_UPDATE,  15, 15, 15, 15, 65535, 1, 0, 15,     0, 0);
		add_row(OP_WRITE,   15, 15, 15,  0,     0, 1, 0,  0,     0, 0);
		add_row(OP_WRITE,    0,  0,  0, 10,     0, 1, 0, 10,     0, 0);
		add_row(OP_UPDATE,  15, 15,  0,  0, 65535, 0, 0,  0,     0, 0);
		add_row(OP_UPDATE,   0,  0,  1, 10, 65535, 0, 0,  0,     0, 0);
		// thresholds at maximum, empty slab
		add_reg(CFG_THRESH_1, 16'hFFFF);
		add_reg(CFG_THRESH_2, 16'hFFFF);
		add_reg(CFG_THRESH_3, 16'hFFFF);
		add_reg(CFG_THRESH_4, 16'hFFFF);
		add_reg(CFG_THRESH_5, 16'hFFFF);
		add_reg(CFG_THRESH_6, 16'hFFFF);
		add_reg(CFG_SLAB_FIRST, 15);
		add_reg(CFG_SLAB_LAST, 0);
		add_row(OP_MEASURE,  0,  0,  0,  3,     0, 1, 0, 10,     0, 0);
		add_row(OP_UPDATE,   0,  0,  1, 10, 65534, 0, 0,  0,     0, 0);
		add_row(OP_UPDATE,   0,  0,  2, 10, 65535, 0, 0,  0,     0, 0);
		add_row(OP_UPDATE,   0,  0,  2, 10,     0, 0, 0,  0,     0, 0);
		add_row(OP_UPDATE,  15, 15, 15, 15,     0, 0, 0,  0,     0, 0);
		add_reg(CFG_SLAB_FIRST, 16'hFFF0);
		add_reg(CFG_THRESH_3, 16'h1234);
		add_row(OP_MEASURE,  0,  0,  0,  0,     0, 0, 0,  0,     0, 0);
		add_reg(CFG_SLAB_FIRST, 15);
		add_reg(CFG_SLAB_LAST, 16'hFFFF);
		add_row(OP_MEASURE, 15,  0, 15,  0,     0, 0, 0,  0,     0, 0);
		add_row(OP_WRITE,    7,  8,  9,  5, 65535, 0, 0,  0,     0, 0);
		add_row(OP_FILL,    15,  0, 15,  0,     0, 1, 0,  0,     0, 0);
		add_row(OP_MEASURE, 15, 15, 15,  0,     0, 1, 0,  0,     0, 0);
		add_row(OP_UPDATE,   3,  3,  3,  0,     0, 1, 0,  0,     0, 0);
		add_row(OP_UPDATE,   3,  3,  3, 15,     0, 1, 1, 15,     0, 0);

		// Hold reset, then release away from the clock edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed rows; registers only change with the block drained
		in_reg = 1'b0;
		foreach (stim_rows[i]) begin
			if (stim_rows[i].is_reg) begin
				if (!in_reg) begin
					wait_idle();
					in_reg = 1'b1;
				end
				write_reg(stim_rows[i].idx, stim_rows[i].data);
			end else begin
				if (in_reg) begin
					@(negedge clk);
					cfg_write_en <= 1'b0;
					in_reg = 1'b0;
				end
				send_row(stim_rows[i]);
			end
		end

		// Random phases: new settings, fill, writes into a small box, then mixed beats
		for (p = 0; p < PHASES; p++) begin
			calm = (p == 3);
			wait_idle();
			lo_v = $urandom_range(0, 15);
			sel = $urandom_range(0, 99);
			if (sel < 15 && lo_v > 0) hi_v = $urandom_range(0, lo_v - 1);
			else if (sel < 30 || lo_v == 15) hi_v = lo_v;
			else hi_v = lo_v + $urandom_range(0, 1);
			data = CFG_DATA_BITS'($urandom_range(0, 65535));
			data[SLAB_BITS-1:0] = SLAB_BITS'(lo_v);
			write_reg(CFG_SLAB_FIRST, data);
			data = CFG_DATA_BITS'($urandom_range(0, 65535));
			data[SLAB_BITS-1:0] = SLAB_BITS'(hi_v);
			write_reg(CFG_SLAB_LAST, data);
			for (k = 1; k <= 6; k++) begin
				sel = $urandom_range(0, 99);
				if (sel < 20) data = '0;
				else if (sel < 40) data = '1;
				else data = CFG_DATA_BITS'($urandom_range(0, 65535));
				write_reg(cfg_reg_t'(int'(CFG_THRESH_1) + k - 1), data);
			end
			@(negedge clk);
			cfg_write_en <= 1'b0;

			case ($urandom_range(0, 3))
				0:       spin_span = 2;
				1:       spin_span = 3;
				2:       spin_span = 4;
				default: spin_span = 16;
			endcase
			box_x = COORD_BITS'($urandom_range(0, 15));
			box_y = COORD_BITS'($urandom_range(0, 15));
			box_z = COORD_BITS'($urandom_range(0, 15));

			row = random_row();
			row.op = OP_FILL;
			row.spin = SPIN_FIELD_BITS'($urandom_range(0, 15));
			send_row(row);
			for (k = 0; k < BOX_WRITES; k++) begin
				row = random_row();
				row.op = OP_WRITE;
				row.x = box_x + COORD_BITS'($urandom_range(0, 2));
				row.y = box_y + COORD_BITS'($urandom_range(0, 2));
				row.z = box_z + COORD_BITS'($urandom_range(0, 2));
				row.spin = SPIN_FIELD_BITS'($urandom_range(0, spin_span - 1));
				send_row(row);
			end
			for (k = 0; k < PHASE_ITEMS - 1 - BOX_WRITES; k++) begin
				send_row(random_row());
			end
		end

		// Drain, let the pipeline settle, then judge
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			flag($sformatf("%0d results never arrived", pending_results.size()));
		end
		$display("tb_top: %0d beats: %0d updates (%0d taken), %0d writes, %0d fills, %0d slab scans",
			n_items, n_updates, n_taken, n_writes, n_fills, n_measures);
		$display("tb_top: %0d register writes over %0d settings, %0d cycles, %0d mismatches",
			n_reg_writes, PHASES + 4, cycle_count, errors);
		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/plmu_pkg.sv
design/plmu_ram.sv
design/plmu_ctrl.sv
design/plmu_datapath.sv
design/potts_lattice_metropolis_update_top.sv
design/plmu_checker.sv
dv/tb_top.sv
